// File: hw/rtl/skoc_pkg.sv
// Shared types and constants for the string key occurrence counter.
// Holds payload structs, controller/datapath command and status types.
// No dependencies.
package skoc_pkg;

    localparam int unsigned TABLE_SLOTS = 2048;
    localparam int unsigned SLOT_W      = 11;
    localparam int unsigned ORD_W       = 12;
    localparam logic [31:0] HASH_INIT   = 32'd2166136261;
    localparam logic [31:0] HASH_MUL    = 32'd16777619;

    localparam logic [2:0] ST_FOUND  = 3'd0;
    localparam logic [2:0] ST_INSERT = 3'd1;
    localparam logic [2:0] ST_DROP   = 3'd2;
    localparam logic [2:0] ST_RDHIT  = 3'd3;
    localparam logic [2:0] ST_RDMISS = 3'd4;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  key_byte;
        logic        key_last;
        logic [11:0] read_ordinal;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [10:0] slot_index;
        logic [11:0] first_seen_ordinal;
        logic [31:0] hit_count;
        logic [2:0]  count_bucket;
        logic        first_drop;
    } out_t;

    typedef enum logic [2:0] {
        RES_INSERT = 3'd0,
        RES_FOUND  = 3'd1,
        RES_DROP   = 3'd2,
        RES_RDHIT  = 3'd3,
        RES_RDMISS = 3'd4
    } res_sel_t;

    typedef struct packed {
        logic     byte_take;
        logic     key_reset;
        logic     rd_take;
        logic     probe_start;
        logic     probe_next;
        logic     meta_sel_o2s;
        logic     hold_meta;
        logic     cnt_clear;
        logic     cnt_inc;
        logic     copy_we;
        logic     ins_we;
        logic     hit_we;
        logic     clr_we;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic enable;
        logic clr_done;
        logic meta_valid;
        logic meta_match;
        logic byte_eq;
        logic cnt_last;
        logic exhausted;
        logic rd_ok;
        logic out_free;
    } stat_t;

    function automatic logic [2:0] bucket_of(input logic [31:0] n);
        logic [2:0] b;
        if (n == 32'd0)           b = 3'd0;
        else if (n == 32'd1)      b = 3'd1;
        else if (n < 32'd10)      b = 3'd2;
        else if (n < 32'd100)     b = 3'd3;
        else if (n < 32'd1000)    b = 3'd4;
        else if (n < 32'd10000)   b = 3'd5;
        else if (n < 32'd100000)  b = 3'd6;
        else                      b = 3'd7;
        return b;
    endfunction

endpackage

// File: hw/rtl/skoc_ctrl.sv
// Controller state machine of the string key occurrence counter.
// Sequences hashing, probing, key compare/copy, reads and result hand-off.
// Depends on skoc_pkg.
module skoc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  skoc_pkg::in_t  s_payload,
    input  skoc_pkg::stat_t stat,
    output skoc_pkg::cmd_t cmd
);
    import skoc_pkg::*;

    typedef enum logic [14:0] {
        S_CLEAR     = 15'b000000000000001,
        S_IDLE      = 15'b000000000000010,
        S_PSTART    = 15'b000000000000100,
        S_PROBE_RD  = 15'b000000000001000,
        S_PROBE_CHK = 15'b000000000010000,
        S_CMP_RD    = 15'b000000000100000,
        S_CMP_CHK   = 15'b000000001000000,
        S_COPY_RD   = 15'b000000010000000,
        S_COPY_WR   = 15'b000000100000000,
        S_INSERT    = 15'b000001000000000,
        S_HIT       = 15'b000010000000000,
        S_RD_CHK    = 15'b000100000000000,
        S_RD_META   = 15'b001000000000000,
        S_RD_DONE   = 15'b010000000000000,
        S_EMIT      = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   take;

    assign s_ready = (state_reg == S_IDLE);
    assign take    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_sel = RES_RDMISS;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_we = 1'b1;
                if (stat.clr_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (take && stat.enable) begin
                    if (s_payload.opcode == OP_READ) begin
                        cmd.rd_take = 1'b1;
                        state_next  = S_RD_CHK;
                    end else begin
                        cmd.byte_take = 1'b1;
                        if (s_payload.key_last) state_next = S_PSTART;
                    end
                end
            end
            S_PSTART: begin
                cmd.probe_start = 1'b1;
                state_next      = S_PROBE_RD;
            end
            S_PROBE_RD: begin
                state_next = S_PROBE_CHK;
            end
            S_PROBE_CHK: begin
                cmd.hold_meta = 1'b1;
                if (!stat.meta_valid) begin
                    cmd.cnt_clear = 1'b1;
                    state_next    = S_COPY_RD;
                end else if (stat.meta_match) begin
                    cmd.cnt_clear = 1'b1;
                    state_next    = S_CMP_RD;
                end else if (stat.exhausted) begin
                    cmd.res_load  = 1'b1;
                    cmd.res_sel   = RES_DROP;
                    cmd.key_reset = 1'b1;
                    state_next    = S_EMIT;
                end else begin
                    cmd.probe_next = 1'b1;
                    state_next     = S_PROBE_RD;
                end
            end
            S_CMP_RD: begin
                state_next = S_CMP_CHK;
            end
            S_CMP_CHK: begin
                if (!stat.byte_eq) begin
                    if (stat.exhausted) begin
                        cmd.res_load  = 1'b1;
                        cmd.res_sel   = RES_DROP;
                        cmd.key_reset = 1'b1;
                        state_next    = S_EMIT;
                    end else begin
                        cmd.probe_next = 1'b1;
                        state_next     = S_PROBE_RD;
                    end
                end else if (stat.cnt_last) begin
                    state_next = S_HIT;
                end else begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_CMP_RD;
                end
            end
            S_COPY_RD: begin
                state_next = S_COPY_WR;
            end
            S_COPY_WR: begin
                cmd.copy_we = 1'b1;
                if (stat.cnt_last) begin
                    state_next = S_INSERT;
                end else begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_COPY_RD;
                end
            end
            S_INSERT: begin
                cmd.ins_we    = 1'b1;
                cmd.res_load  = 1'b1;
                cmd.res_sel   = RES_INSERT;
                cmd.key_reset = 1'b1;
                state_next    = S_EMIT;
            end
            S_HIT: begin
                cmd.hit_we    = 1'b1;
                cmd.res_load  = 1'b1;
                cmd.res_sel   = RES_FOUND;
                cmd.key_reset = 1'b1;
                state_next    = S_EMIT;
            end
            S_RD_CHK: begin
                if (stat.rd_ok) begin
                    state_next = S_RD_META;
                end else begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_RDMISS;
                    state_next   = S_EMIT;
                end
            end
            S_RD_META: begin
                cmd.meta_sel_o2s = 1'b1;
                state_next       = S_RD_DONE;
            end
            S_RD_DONE: begin
                cmd.meta_sel_o2s = 1'b1;
                cmd.res_load     = 1'b1;
                cmd.res_sel      = RES_RDHIT;
                state_next       = S_EMIT;
            end
            S_EMIT: begin
                // hold the result until the output register frees up
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// File: hw/rtl/skoc_dp.sv
// Datapath of the string key occurrence counter: hash, pending key buffer,
// slot table memories, ordinal map, result and output registers.
// Depends on skoc_pkg.
module skoc_dp #(
    parameter int unsigned KEY_BUFFER = 96
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic            cfg_data,
    input  skoc_pkg::in_t   s_payload,
    input  skoc_pkg::cmd_t  cmd,
    output skoc_pkg::stat_t stat,
    input  logic            m_ready,
    output logic            m_valid,
    output skoc_pkg::out_t  m_payload
);
    import skoc_pkg::*;

    localparam int unsigned KEY_MAX = KEY_BUFFER - 1;
    localparam int unsigned IDX_W   = $clog2(KEY_MAX);
    localparam int unsigned LEN_W   = $clog2(KEY_BUFFER);
    localparam int unsigned KADDR_W = SLOT_W + IDX_W;

    typedef struct packed {
        logic              valid;
        logic [LEN_W-1:0]  len;
        logic [31:0]       hash;
        logic [ORD_W-1:0]  ord;
        logic [31:0]       hits;
    } meta_t;

    logic                enable_reg;
    logic [LEN_W-1:0]    plen_reg;
    logic [31:0]         hash_reg;
    logic [ORD_W-1:0]    next_ord_reg;
    logic                full_flag_reg;
    logic [SLOT_W-1:0]   clr_idx_reg;
    logic [SLOT_W-1:0]   probe_slot_reg;
    logic [ORD_W-1:0]    probe_cnt_reg;
    logic [IDX_W-1:0]    cnt_reg;
    logic [ORD_W-1:0]    rd_ord_reg;
    meta_t               meta_hold_reg;
    out_t                res_reg;
    logic                m_valid_reg;
    out_t                m_payload_reg;

    logic [7:0]          pend_mem [KEY_MAX];
    logic [7:0]          pend_q;
    logic [7:0]          key_mem [TABLE_SLOTS << IDX_W];
    logic [7:0]          key_q;
    meta_t               meta_mem [TABLE_SLOTS];
    meta_t               meta_q;
    logic [SLOT_W-1:0]   o2s_mem [TABLE_SLOTS + 1];
    logic [SLOT_W-1:0]   o2s_q;

    logic                room;
    logic [KADDR_W-1:0]  key_addr;
    logic                meta_we;
    logic [SLOT_W-1:0]   meta_waddr;
    meta_t               meta_wdata;
    logic [SLOT_W-1:0]   meta_raddr;
    logic [ORD_W-1:0]    ins_ord;
    logic [31:0]         hits_inc;
    out_t                res_next;

    assign room       = (plen_reg < LEN_W'(KEY_MAX));
    assign key_addr   = {probe_slot_reg, cnt_reg};
    assign meta_raddr = cmd.meta_sel_o2s ? o2s_q : probe_slot_reg;
    assign ins_ord    = next_ord_reg + ORD_W'(1);
    assign hits_inc   = meta_hold_reg.hits + 32'd1;

    always_comb begin
        meta_we    = 1'b0;
        meta_waddr = probe_slot_reg;
        meta_wdata = meta_hold_reg;
        if (cmd.clr_we) begin
            meta_we    = 1'b1;
            meta_waddr = clr_idx_reg;
            meta_wdata = '0;
        end else if (cmd.ins_we) begin
            meta_we    = 1'b1;
            meta_wdata = '{valid: 1'b1, len: plen_reg, hash: hash_reg,
                           ord: ins_ord, hits: 32'd1};
        end else if (cmd.hit_we) begin
            meta_we         = 1'b1;
            meta_wdata.hits = hits_inc;
        end
    end

    // memories, registered reads
    always_ff @(posedge aclk) begin
        if (cmd.byte_take && room) begin
            pend_mem[plen_reg[IDX_W-1:0]] <= s_payload.key_byte;
        end
        pend_q <= pend_mem[cnt_reg];
        if (cmd.copy_we) begin
            key_mem[key_addr] <= pend_q;
        end
        key_q <= key_mem[key_addr];
        if (meta_we) begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        meta_q <= meta_mem[meta_raddr];
        if (cmd.ins_we) begin
            o2s_mem[ins_ord] <= probe_slot_reg;
        end
        o2s_q <= o2s_mem[rd_ord_reg];
    end

    always_comb begin
        res_next = '0;
        case (cmd.res_sel)
            RES_INSERT: begin
                res_next.status             = ST_INSERT;
                res_next.slot_index         = probe_slot_reg;
                res_next.first_seen_ordinal = ins_ord;
                res_next.hit_count          = 32'd1;
                res_next.count_bucket       = bucket_of(32'd1);
            end
            RES_FOUND: begin
                res_next.status             = ST_FOUND;
                res_next.slot_index         = probe_slot_reg;
                res_next.first_seen_ordinal = meta_hold_reg.ord;
                res_next.hit_count          = hits_inc;
                res_next.count_bucket       = bucket_of(hits_inc);
            end
            RES_DROP: begin
                res_next.status     = ST_DROP;
                res_next.first_drop = !full_flag_reg;
            end
            RES_RDHIT: begin
                res_next.status             = ST_RDHIT;
                res_next.slot_index         = o2s_q;
                res_next.first_seen_ordinal = rd_ord_reg;
                res_next.hit_count          = meta_q.hits;
                res_next.count_bucket       = bucket_of(meta_q.hits);
            end
            default: begin
                res_next.status = ST_RDMISS;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b0;
            plen_reg      <= '0;
            hash_reg      <= HASH_INIT;
            next_ord_reg  <= '0;
            full_flag_reg <= 1'b0;
            clr_idx_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) enable_reg <= cfg_data;
            if (cmd.key_reset) begin
                plen_reg <= '0;
                hash_reg <= HASH_INIT;
            end else if (cmd.byte_take && room) begin
                plen_reg <= plen_reg + LEN_W'(1);
                hash_reg <= (hash_reg ^ {24'd0, s_payload.key_byte}) * HASH_MUL;
            end
            if (cmd.ins_we) next_ord_reg <= ins_ord;
            if (cmd.res_load && cmd.res_sel == RES_DROP) full_flag_reg <= 1'b1;
            if (cmd.clr_we) clr_idx_reg <= clr_idx_reg + SLOT_W'(1);
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.probe_start) begin
            probe_slot_reg <= hash_reg[SLOT_W-1:0];
            probe_cnt_reg  <= '0;
        end else if (cmd.probe_next) begin
            probe_slot_reg <= probe_slot_reg + SLOT_W'(1);
            probe_cnt_reg  <= probe_cnt_reg + ORD_W'(1);
        end
        if (cmd.cnt_clear) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + IDX_W'(1);
        end
        if (cmd.rd_take)   rd_ord_reg    <= s_payload.read_ordinal;
        if (cmd.hold_meta) meta_hold_reg <= meta_q;
        if (cmd.res_load)  res_reg       <= res_next;
        if (cmd.out_load)  m_payload_reg <= res_reg;
    end

    assign stat.enable     = enable_reg;
    assign stat.clr_done   = (clr_idx_reg == SLOT_W'(TABLE_SLOTS - 1));
    assign stat.meta_valid = meta_q.valid;
    assign stat.meta_match = (meta_q.len == plen_reg) && (meta_q.hash == hash_reg);
    assign stat.byte_eq    = (key_q == pend_q);
    assign stat.cnt_last   = ((LEN_W'(cnt_reg) + LEN_W'(1)) == plen_reg);
    assign stat.exhausted  = (probe_cnt_reg == ORD_W'(TABLE_SLOTS - 1));
    assign stat.rd_ok      = (rd_ord_reg != '0) && (rd_ord_reg <= next_ord_reg);
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

// File: hw/rtl/string_key_occurrence_counter_unit.sv
// A key byte without key_last gives no result. A key end probes slots from its hash,
// compares bytes for each slot whose stored length and hash agree, copies in a new key
// on an empty slot, or drops the key once all slots are probed; a read looks up by ordinal.
// One word in flight at a time; the next word can be taken the cycle after out_load.
// Reset (aresetn low, synchronous): a pass over all slots then clears the slot table,
// no word is taken meanwhile; configuration writes are taken throughout.
module string_key_occurrence_counter_unit #(
    parameter int unsigned KEY_BUFFER = 96
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic           cfg_data,
    input  logic           s_valid,
    output logic           s_ready,
    input  skoc_pkg::in_t  s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output skoc_pkg::out_t m_payload
);
    import skoc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    skoc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .stat      (stat),
        .cmd       (cmd)
    );

    skoc_dp #(
        .KEY_BUFFER (KEY_BUFFER)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .s_payload (s_payload),
        .cmd       (cmd),
        .stat      (stat),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_payload (m_payload)
    );

    a_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && stat.enable && s_payload.opcode == OP_KEY &&
        s_payload.key_last |=> !s_ready)
        else $error("took a word during key lookup");

    a_drop_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.first_drop |-> m_payload.status == ST_DROP)
        else $error("drop flag on a non-drop result");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.status == ST_RDMISS || m_payload.status == ST_DROP)
        |-> m_payload.hit_count == 32'd0 && m_payload.slot_index == '0)
        else $error("miss or drop carries data");

    a_insert_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.status == ST_INSERT
        |-> m_payload.hit_count == 32'd1 && m_payload.first_seen_ordinal != '0)
        else $error("bad insert result");

endmodule
